[rtl/alpha_subset_integer_core_macros.svh]
// assertion macros for the alpha subset integer core
// no dependencies; included by modules that carry assertions
`ifndef ALPHA_SUBSET_INTEGER_CORE_MACROS_SVH
`define ALPHA_SUBSET_INTEGER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ASIC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASIC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASIC_ASSERT(label, clk, rst_n, prop, msg)
`define ASIC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[rtl/asic_pkg.sv]
// shared types, codes and helpers of the alpha subset integer core
// no dependencies
package asic_pkg;

  localparam int unsigned MEM_WORDS_DEF = 16384;
  localparam int unsigned NUM_REGS_DEF  = 32;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_HALT    = 3'd1;
  localparam logic [2:0] ST_END     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_LDRANGE = 3'd4;
  localparam logic [2:0] ST_STRANGE = 3'd5;
  localparam logic [2:0] ST_RDONLY  = 3'd6;
  localparam logic [2:0] ST_FETCH   = 3'd7;

  // actions
  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_EXEC = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // opcodes
  localparam logic [5:0] OP_LDA  = 6'h08;
  localparam logic [5:0] OP_LDAH = 6'h09;
  localparam logic [5:0] OP_ITOF = 6'h14;
  localparam logic [5:0] OP_INTA = 6'h10;
  localparam logic [5:0] OP_INTL = 6'h11;
  localparam logic [5:0] OP_INTS = 6'h12;
  localparam logic [5:0] OP_JMP  = 6'h1A;
  localparam logic [5:0] OP_FTOI = 6'h1C;
  localparam logic [5:0] OP_LDS  = 6'h22;
  localparam logic [5:0] OP_STS  = 6'h26;
  localparam logic [5:0] OP_LDL  = 6'h28;
  localparam logic [5:0] OP_STL  = 6'h2C;
  localparam logic [5:0] OP_BR   = 6'h30;
  localparam logic [5:0] OP_FBEQ = 6'h31;
  localparam logic [5:0] OP_BSR  = 6'h34;
  localparam logic [5:0] OP_FBNE = 6'h35;
  localparam logic [5:0] OP_BEQ  = 6'h39;
  localparam logic [5:0] OP_BNE  = 6'h3D;

  // operate functions
  localparam logic [6:0] FN_ADD  = 7'h00;
  localparam logic [6:0] FN_SUB  = 7'h09;
  localparam logic [6:0] FN_CEQ  = 7'h2D;
  localparam logic [6:0] FN_CLE  = 7'h6D;
  localparam logic [6:0] FN_CLT  = 7'h4D;
  localparam logic [6:0] FN_AND  = 7'h00;
  localparam logic [6:0] FN_OR   = 7'h20;
  localparam logic [6:0] FN_XOR  = 7'h40;
  localparam logic [6:0] FN_EQV  = 7'h48;
  localparam logic [6:0] FN_SLL  = 7'h39;
  localparam logic [6:0] FN_SRL  = 7'h34;
  localparam logic [6:0] FN_SRA  = 7'h3C;
  localparam logic [10:0] FN_FTOIS = 11'h078;
  localparam logic [10:0] FN_ITOFS = 11'h004;

  typedef struct packed {
    logic [1:0]  action;
    logic [13:0] addr;
    logic [31:0] data;
    logic [7:0]  console_byte;
  } asic_in_t;

  typedef struct packed {
    logic [31:0] pc_value;
    logic [2:0]  status;
    logic [31:0] read_data;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        input_taken;
  } asic_out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_DECODE, S_MEMRD, S_MEMWB, S_DONE
  } asic_state_t;

  // register file write request
  typedef struct packed {
    logic        en;
    logic        flt;
    logic [4:0]  idx;
    logic [31:0] val;
  } asic_rwr_t;

  function automatic logic [31:0] sext16(input logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

endpackage

[rtl/asic_ram.sv]
// generic simple dual-port synchronous ram (one write port, one read port) with registered read
// no dependencies
module asic_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/asic_alu.sv]
// integer operate unit: add, sub, compare, logic and shifts
// depends on asic_pkg
module asic_alu (
  input  logic [5:0]  op,
  input  logic [6:0]  fn,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] res,
  output logic        known
);
  import asic_pkg::*;

  logic [31:0] sa, sb, fill;
  logic        big;
  logic [4:0]  sh;

  always_comb begin
    sa    = a ^ 32'h8000_0000;
    sb    = b ^ 32'h8000_0000;
    fill  = {32{a[31]}};
    big   = (b[31:5] != 27'd0);
    sh    = b[4:0];
    res   = 32'd0;
    known = 1'b1;
    case (op)
      OP_INTA: begin
        case (fn)
          FN_ADD:  res = a + b;
          FN_SUB:  res = a - b;
          FN_CEQ:  res = {31'd0, a == b};
          FN_CLE:  res = {31'd0, sa <= sb};
          FN_CLT:  res = {31'd0, sa < sb};
          default: known = 1'b0;
        endcase
      end
      OP_INTL: begin
        case (fn)
          FN_AND:  res = a & b;
          FN_OR:   res = a | b;
          FN_XOR:  res = a ^ b;
          FN_EQV:  res = a ^ ~b;
          default: known = 1'b0;
        endcase
      end
      OP_INTS: begin
        case (fn)
          FN_SLL:  res = big ? 32'd0 : (a << sh);
          FN_SRL:  res = big ? 32'd0 : (a >> sh);
          FN_SRA:  res = big ? fill : 32'($signed(a) >>> sh);
          default: known = 1'b0;
        endcase
      end
      default: known = 1'b0;
    endcase
  end
endmodule

[rtl/asic_regfile.sv]
// integer and float register files with reset clear by valid bits
// depends on asic_pkg
module asic_regfile #(
  parameter int unsigned NUM_REGS = asic_pkg::NUM_REGS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  asic_pkg::asic_rwr_t     wr,
  input  logic [4:0]              ia_idx,
  input  logic [4:0]              ib_idx,
  input  logic [4:0]              fa_idx,
  output logic [31:0]             ia_val,
  output logic [31:0]             ib_val,
  output logic [31:0]             fa_val
);
  import asic_pkg::*;

  logic [31:0]         iregs [NUM_REGS];
  logic [31:0]         fregs [NUM_REGS];
  logic [NUM_REGS-1:0] ivld_r, fvld_r;

  // writes to register 31 are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r <= '0;
      fvld_r <= '0;
    end else if (wr.en && wr.idx != 5'd31) begin
      if (wr.flt) begin
        fvld_r[wr.idx] <= 1'b1;
      end else begin
        ivld_r[wr.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.idx != 5'd31) begin
      if (wr.flt) begin
        fregs[wr.idx] <= wr.val;
      end else begin
        iregs[wr.idx] <= wr.val;
      end
    end
  end

  assign ia_val = ivld_r[ia_idx] ? iregs[ia_idx] : 32'd0;
  assign ib_val = ivld_r[ib_idx] ? iregs[ib_idx] : 32'd0;
  assign fa_val = fvld_r[fa_idx] ? fregs[fa_idx] : 32'd0;
endmodule

[rtl/alpha_subset_integer_core.sv]
// Alpha-subset integer core: one request per item, one result per request.
// Every request passes through S_FETCH and then S_DONE. A memory-write or
// register-read request goes straight from S_FETCH to S_DONE, as does an
// execute request that is not fetched (halted, end of program, pc out of
// range). An executed instruction is read from ram in S_FETCH, then decoded
// and executed in S_DECODE; a store adds S_MEMWB for the ram write or console
// update, and a load adds S_MEMRD (a ram read of the effective address), then
// S_MEMWB for write-back. The sequencer returns to S_IDLE before it takes the
// next request, and a result that is not taken holds off the next request.
// Registers and pc clear on reset; the word ram does not.
// depends on asic_pkg, asic_ram, asic_alu, asic_regfile and the macros header
`include "alpha_subset_integer_core_macros.svh"
module alpha_subset_integer_core #(
  parameter int unsigned MEM_WORDS = asic_pkg::MEM_WORDS_DEF,
  parameter int unsigned NUM_REGS  = asic_pkg::NUM_REGS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  asic_pkg::asic_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output asic_pkg::asic_out_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [1:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import asic_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  asic_state_t state_r, state_nxt;
  asic_in_t    req_r, req_nxt;
  asic_out_t   res_r, res_nxt;
  logic [31:0] pc_r, pc_nxt;
  logic        halted_r, halted_nxt;
  logic [7:0]  latch_r, latch_nxt;
  logic [14:0] plen_r;
  logic [31:0] inst_r, inst_nxt;
  logic [31:0] ea_r, ea_nxt;

  // ram port
  logic           m_we;
  logic [AW-1:0]  m_waddr, m_raddr;
  logic [31:0]    m_wdata, m_rdata;

  asic_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_mem (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  // register files
  asic_rwr_t   rwr;
  logic [4:0]  ia_idx, ib_idx, fa_idx;
  logic [31:0] ia_val, ib_val, fa_val;

  asic_regfile #(.NUM_REGS(NUM_REGS)) u_rf (
    .clk(clk), .rst_n(rst_n), .wr(rwr), .ia_idx(ia_idx), .ib_idx(ib_idx),
    .fa_idx(fa_idx), .ia_val(ia_val), .ib_val(ib_val), .fa_val(fa_val)
  );

  // decode fields of the fetched word
  logic [31:0] inst;
  logic [5:0]  op;
  logic [4:0]  ra, rb, rc;
  logic [31:0] disp, ea_c, btgt;
  logic [31:0] alu_b, alu_res;
  logic        alu_known;

  assign inst   = (state_r == S_DECODE) ? m_rdata : inst_r;
  assign op     = inst[31:26];
  assign ra     = inst[25:21];
  assign rb     = inst[20:16];
  assign rc     = inst[4:0];
  assign disp   = sext16(inst);
  assign ea_c   = ib_val + disp;
  assign btgt   = pc_r + disp;
  assign alu_b  = inst[12] ? {24'd0, inst[20:13]} : ib_val;

  always_comb begin
    ia_idx = ra;
    ib_idx = rb;
    fa_idx = ra;
    if (state_r == S_IDLE || state_r == S_FETCH) begin
      ia_idx = req_r.addr[4:0];
      fa_idx = req_r.addr[4:0];
    end
  end

  asic_alu u_alu (
    .op(op), .fn(inst[11:5]), .a(ia_val), .b(alu_b),
    .res(alu_res), .known(alu_known)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {17'd0, plen_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      plen_r <= cfg_pwdata[14:0];
    end
  end

  // ea classification helpers
  logic        ea_mem, ea_st0, ea_rd1, ea_st2, ea_wd3;
  logic [31:0] ea_off;
  always_comb begin
    ea_mem = (ea_r < 32'(MEM_WORDS));
    ea_off = ea_r - 32'(MEM_WORDS);
    ea_st0 = (ea_off == 32'd0);
    ea_rd1 = (ea_off == 32'd1);
    ea_st2 = (ea_off == 32'd2);
    ea_wd3 = (ea_off == 32'd3);
  end

  assign in_ready  = (state_r == S_IDLE) && !(out_valid && !out_ready);
  assign out_data  = res_r;

  logic ovld_r, ovld_nxt;
  assign out_valid = ovld_r;

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    req_nxt    = req_r;
    res_nxt    = res_r;
    pc_nxt     = pc_r;
    halted_nxt = halted_r;
    latch_nxt  = latch_r;
    inst_nxt   = inst_r;
    ea_nxt     = ea_r;
    ovld_nxt   = ovld_r && !out_ready;
    m_we       = 1'b0;
    m_waddr    = AW'(req_r.addr);
    m_wdata    = req_r.data;
    m_raddr    = AW'(pc_r);
    rwr        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          req_nxt   = in_data;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        res_nxt   = '0;
        state_nxt = S_DONE;
        case (req_r.action)
          ACT_LOAD: begin
            m_we = (32'(req_r.addr) < 32'(MEM_WORDS));
          end
          ACT_READ: begin
            if (req_r.addr < 14'd32) begin
              res_nxt.read_data = ia_val;
            end else if (req_r.addr < 14'd64) begin
              res_nxt.read_data = fa_val;
            end
          end
          ACT_EXEC: begin
            if (halted_r) begin
              res_nxt.status = ST_HALT;
            end else if (pc_r == {17'd0, plen_r}) begin
              res_nxt.status = ST_END;
            end else if (pc_r >= 32'(MEM_WORDS)) begin
              res_nxt.status = ST_FETCH;
            end else begin
              state_nxt = S_DECODE;
            end
          end
          default: ;
        endcase
      end
      S_DECODE: begin
        inst_nxt  = m_rdata;
        ea_nxt    = ea_c;
        state_nxt = S_DONE;
        pc_nxt    = pc_r + 32'd1;
        case (op)
          OP_LDA:  rwr = '{en: 1'b1, flt: 1'b0, idx: ra, val: ea_c};
          OP_LDAH: rwr = '{en: 1'b1, flt: 1'b0, idx: ra, val: ib_val + {disp[15:0], 16'd0}};
          OP_LDS, OP_LDL: begin
            pc_nxt    = pc_r;
            state_nxt = S_MEMRD;
          end
          OP_STS, OP_STL: begin
            pc_nxt    = pc_r;
            state_nxt = S_MEMWB;
          end
          OP_JMP: begin
            if (inst[15:14] == 2'd3) begin
              pc_nxt = pc_r;
              res_nxt.status = ST_UNKNOWN;
            end else begin
              rwr    = '{en: 1'b1, flt: 1'b0, idx: ra, val: pc_r + 32'd1};
              pc_nxt = ib_val;
            end
          end
          OP_FTOI: begin
            if (inst[15:5] == FN_FTOIS) begin
              rwr = '{en: 1'b1, flt: 1'b0, idx: rc, val: fa_val};
            end else begin
              pc_nxt = pc_r;
              res_nxt.status = ST_UNKNOWN;
            end
          end
          OP_ITOF: begin
            if (inst[15:5] == FN_ITOFS) begin
              rwr = '{en: 1'b1, flt: 1'b1, idx: rc, val: ia_val};
            end else begin
              pc_nxt = pc_r;
              res_nxt.status = ST_UNKNOWN;
            end
          end
          OP_BR: begin
            rwr = '{en: 1'b1, flt: 1'b0, idx: ra, val: pc_r + 32'd1};
            if (inst[20:0] == 21'd0) begin
              halted_nxt = 1'b1;
              pc_nxt = pc_r;
              res_nxt.status = ST_HALT;
            end else begin
              pc_nxt = btgt;
            end
          end
          OP_BSR: begin
            rwr    = '{en: 1'b1, flt: 1'b0, idx: ra, val: pc_r + 32'd1};
            pc_nxt = btgt;
          end
          OP_BEQ:  if (ia_val == 32'd0) pc_nxt = btgt;
          OP_BNE:  if (ia_val != 32'd0) pc_nxt = btgt;
          OP_FBEQ: if (fa_val[30:0] == 31'd0) pc_nxt = btgt;
          OP_FBNE: if (fa_val[30:0] != 31'd0) pc_nxt = btgt;
          OP_INTA, OP_INTL, OP_INTS: begin
            if (alu_known) begin
              rwr = '{en: 1'b1, flt: 1'b0, idx: rc, val: alu_res};
            end else begin
              pc_nxt = pc_r;
              res_nxt.status = ST_UNKNOWN;
            end
          end
          default: begin
            pc_nxt = pc_r;
            res_nxt.status = ST_UNKNOWN;
          end
        endcase
      end
      S_MEMRD: begin
        // ram read of the effective address, data lands next cycle
        m_raddr   = ea_r[AW-1:0];
        state_nxt = S_MEMWB;
      end
      S_MEMWB: begin
        state_nxt = S_DONE;
        pc_nxt    = pc_r + 32'd1;
        if (op == OP_LDS || op == OP_LDL) begin
          if (ea_mem) begin
            rwr = '{en: 1'b1, flt: (op == OP_LDS), idx: ra, val: m_rdata};
          end else if (ea_st0 || ea_st2) begin
            rwr = '{en: 1'b1, flt: (op == OP_LDS), idx: ra, val: 32'd1};
          end else if (ea_rd1) begin
            rwr = '{en: 1'b1, flt: (op == OP_LDS), idx: ra,
                    val: {24'd0, req_r.console_byte}};
            res_nxt.input_taken = 1'b1;
          end else if (ea_wd3) begin
            rwr = '{en: 1'b1, flt: (op == OP_LDS), idx: ra, val: {24'd0, latch_r}};
          end else begin
            res_nxt.status = ST_LDRANGE;
          end
        end else begin
          m_waddr = ea_r[AW-1:0];
          m_wdata = (op == OP_STS) ? fa_val : ia_val;
          if (ea_mem) begin
            m_we = 1'b1;
          end else if (ea_wd3) begin
            latch_nxt = m_wdata[7:0];
            res_nxt.out_byte  = m_wdata[7:0];
            res_nxt.out_valid = 1'b1;
          end else if (ea_st0 || ea_rd1 || ea_st2) begin
            res_nxt.status = ST_RDONLY;
          end else begin
            res_nxt.status = ST_STRANGE;
          end
        end
      end
      S_DONE: begin
        if (!ovld_r || out_ready) begin
          res_nxt.pc_value = pc_r;
          ovld_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pc_r     <= '0;
      halted_r <= 1'b0;
      latch_r  <= '0;
      ovld_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      halted_r <= halted_nxt;
      latch_r  <= latch_nxt;
      ovld_r   <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    res_r  <= res_nxt;
    inst_r <= inst_nxt;
    ea_r   <= ea_nxt;
  end

  `ASIC_ASSERT(a_halt_sticky, clk, rst_n, $past(halted_r) |-> halted_r, "halted cleared")
  `ASIC_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> (state_r == S_IDLE), "ready off idle")
  `ASIC_ASSERT(a_halt_pc, clk, rst_n, halted_r |=> $stable(pc_r), "pc moved while halted")
  `ASIC_ASSERT(a_one_req, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "second request")
endmodule
